// File: src/id_grade_record_histogram_unit_assert.svh
// Assertion macros for the grade-record histogram unit.
`ifndef ID_GRADE_RECORD_HISTOGRAM_UNIT_ASSERT_SVH
`define ID_GRADE_RECORD_HISTOGRAM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define IDGRH_ASSERT_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IDGRH_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDGRH_ASSERT_RST(name, clk, rst, prop, msg)
`define IDGRH_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: src/idgrh_pkg.sv
// Shared types and constants of the grade-record histogram unit.
`timescale 1ns / 1ps
package idgrh_pkg;

   localparam int COUNT_WIDTH  = 24;
   localparam int MAX_LINE_LEN = 99;
   localparam int ID_WIDTH     = 31;
   localparam int ACC_WIDTH    = 32;
   localparam int GRADE_WIDTH  = 10;
   localparam int LEN_WIDTH    = 7;
   localparam int NUM_BINS     = 10;
   localparam int BIN_WIDTH    = 4;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_NUL     = 8'd0;
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_COMMA   = 8'd44;
   localparam logic [7:0] CHAR_MINUS   = 8'd45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;

   localparam logic [GRADE_WIDTH-1:0] GRADE_FULL = 10'd100;

   // line verdict codes
   localparam logic [1:0] VERDICT_PARSING = 2'd0;
   localparam logic [1:0] VERDICT_REJECT  = 2'd1;
   localparam logic [1:0] VERDICT_BAD     = 2'd2;
   localparam logic [1:0] VERDICT_STOPPED = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_ACCEPTED  = 2'd0;
   localparam logic [1:0] STATUS_REJECTED  = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;

   // register indexes
   localparam logic CSR_MIN_ID = 1'b0;
   localparam logic CSR_MAX_ID = 1'b1;

   typedef struct packed {
      logic [ACC_WIDTH-1:0]   id;
      logic [GRADE_WIDTH-1:0] grade;
      logic [1:0]             verdict;
      logic                   too_long;
   } line_snap_type;

   // bin of a grade: grade / 10, with 100 and above in the top bin
   function automatic logic [BIN_WIDTH-1:0] bin_of(input logic [GRADE_WIDTH-1:0] grade);
      logic [BIN_WIDTH-1:0] bin;
      bin = '0;
      for (int k = 1; k < NUM_BINS; k++) begin
         if (grade >= GRADE_WIDTH'(k * 10)) begin
            bin = bin + 1'b1;
         end
      end
      return bin;
   endfunction

endpackage

// File: src/idgrh_parser.sv
// Byte-level line parser: builds id, grade, verdict and length of the open line.
`timescale 1ns / 1ps
module idgrh_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       byte_accept,
   input  logic [7:0]                 data_byte,
   output idgrh_pkg::line_snap_type   line_snap
);
   import idgrh_pkg::*;

   localparam logic [2:0] ST_START = 3'd0;
   localparam logic [2:0] ST_WS1   = 3'd1;
   localparam logic [2:0] ST_WS2   = 3'd2;
   localparam logic [2:0] ST_WS3   = 3'd3;
   localparam logic [2:0] ST_WS4   = 3'd4;
   localparam logic [2:0] ST_ID    = 3'd5;
   localparam logic [2:0] ST_COMMA = 3'd6;
   localparam logic [2:0] ST_GRADE = 3'd7;

   logic [2:0]             state_ff,   state_in;
   logic [ACC_WIDTH-1:0]   id_ff,      id_in;
   logic [GRADE_WIDTH-1:0] grade_ff,   grade_in;
   logic [1:0]             verdict_ff, verdict_in;
   logic [LEN_WIDTH-1:0]   length_ff,  length_in;

   logic                   is_digit, is_blank, is_comma, is_minus;
   logic [3:0]             digit;
   logic [ACC_WIDTH+3:0]   id_next;
   logic [GRADE_WIDTH+3:0] grade_next;
   logic [ACC_WIDTH-1:0]   id_sat;
   logic [GRADE_WIDTH-1:0] grade_sat;

   always_comb begin
      is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
      is_blank = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB);
      is_comma = (data_byte == CHAR_COMMA);
      is_minus = (data_byte == CHAR_MINUS);
      digit    = data_byte[3:0];

      // times ten as shift and add, then clamp
      id_next    = {1'b0, id_ff, 3'b000} + {3'b000, id_ff, 1'b0}
                   + {{ACC_WIDTH{1'b0}}, digit};
      grade_next = {1'b0, grade_ff, 3'b000} + {3'b000, grade_ff, 1'b0}
                   + {{GRADE_WIDTH{1'b0}}, digit};
      id_sat     = (id_next[ACC_WIDTH+3:ACC_WIDTH] != '0) ? {ACC_WIDTH{1'b1}}
                                                          : id_next[ACC_WIDTH-1:0];
      grade_sat  = (grade_next[GRADE_WIDTH+3:GRADE_WIDTH] != '0) ? {GRADE_WIDTH{1'b1}}
                                                                  : grade_next[GRADE_WIDTH-1:0];
   end

   always_comb begin
      state_in   = state_ff;
      id_in      = id_ff;
      grade_in   = grade_ff;
      verdict_in = verdict_ff;
      length_in  = length_ff;
      if (byte_accept) begin
         if (data_byte == CHAR_NEWLINE) begin
            state_in   = ST_START;
            id_in      = '0;
            grade_in   = '0;
            verdict_in = VERDICT_PARSING;
            length_in  = '0;
         end else begin
            if (length_ff != {LEN_WIDTH{1'b1}}) begin
               length_in = length_ff + 1'b1;
            end
            if (verdict_ff == VERDICT_PARSING) begin
               if (data_byte == CHAR_NUL) begin
                  verdict_in = VERDICT_STOPPED;
               end else begin
                  case (state_ff)
                     ST_START, ST_WS1: begin
                        if (is_blank) begin
                           state_in = ST_WS1;
                        end else if (is_digit) begin
                           id_in    = {{(ACC_WIDTH-4){1'b0}}, digit};
                           state_in = ST_ID;
                        end else begin
                           verdict_in = VERDICT_BAD;
                        end
                     end
                     ST_ID: begin
                        if (is_digit) begin
                           id_in = id_sat;
                        end else if (is_blank) begin
                           state_in = ST_WS2;
                        end else if (is_comma) begin
                           state_in = ST_COMMA;
                        end else begin
                           verdict_in = VERDICT_BAD;
                        end
                     end
                     ST_WS2: begin
                        if (is_blank) begin
                           state_in = ST_WS2;
                        end else if (is_comma) begin
                           state_in = ST_COMMA;
                        end else begin
                           verdict_in = VERDICT_BAD;
                        end
                     end
                     ST_COMMA, ST_WS3: begin
                        if (is_digit) begin
                           grade_in = {{(GRADE_WIDTH-4){1'b0}}, digit};
                           state_in = ST_GRADE;
                        end else if (is_blank) begin
                           state_in = ST_WS3;
                        end else if (is_minus) begin
                           verdict_in = VERDICT_REJECT;
                        end else begin
                           verdict_in = VERDICT_BAD;
                        end
                     end
                     ST_GRADE: begin
                        if (is_digit) begin
                           grade_in = grade_sat;
                        end else if (is_blank) begin
                           state_in = ST_WS4;
                        end else if (is_minus) begin
                           verdict_in = VERDICT_REJECT;
                        end else begin
                           verdict_in = VERDICT_BAD;
                        end
                     end
                     default: begin
                        if (!is_blank) begin
                           verdict_in = VERDICT_BAD;
                        end
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_START;
         id_ff      <= '0;
         grade_ff   <= '0;
         verdict_ff <= VERDICT_PARSING;
         length_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         id_ff      <= id_in;
         grade_ff   <= grade_in;
         verdict_ff <= verdict_in;
         length_ff  <= length_in;
      end
   end

   assign line_snap.id       = id_ff;
   assign line_snap.grade    = grade_ff;
   assign line_snap.verdict  = verdict_ff;
   assign line_snap.too_long = (length_ff > LEN_WIDTH'(MAX_LINE_LEN));

endmodule

// File: src/id_grade_record_histogram_unit.sv
// Top level of the grade-record histogram unit: line judging, bins and result word.
// A newline that is taken gives its result word through the line register, then the output
// register; other bytes give no word.
// Throughput: one byte per cycle; input stalls only while a finished line waits in the
// line register behind a stalled result word in the output register.
// Reset (sync, active high) clears parser, counters, sticky error, bins; ids 22200000/22299999.
`timescale 1ns / 1ps
`include "id_grade_record_histogram_unit_assert.svh"
module id_grade_record_histogram_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_line_status,
   output logic [23:0] rsp_line_number,
   output logic [3:0]  rsp_bin_index,
   output logic [23:0] rsp_bin_count,
   output logic [23:0] rsp_reject_total,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata
);
   import idgrh_pkg::*;

   logic                   req_accept, newline_accept, judge_fire;
   line_snap_type          cur_snap;

   logic [ID_WIDTH-1:0]    min_id_ff, min_id_in;
   logic [ID_WIDTH-1:0]    max_id_ff, max_id_in;

   logic                   evt_valid_ff, evt_valid_in;
   line_snap_type          evt_snap_ff;

   logic                   sticky_ff, sticky_in;
   logic [COUNT_WIDTH-1:0] line_cnt_ff, line_cnt_in;
   logic [COUNT_WIDTH-1:0] reject_cnt_ff, reject_cnt_in;
   logic [COUNT_WIDTH-1:0] bins_ff [NUM_BINS];
   logic [COUNT_WIDTH-1:0] bin_new;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   logic [COUNT_WIDTH-1:0] line_num_ff;
   logic [BIN_WIDTH-1:0]   bin_idx_ff, bin_idx_in;
   logic [COUNT_WIDTH-1:0] bin_cnt_ff, bin_cnt_in;
   logic [COUNT_WIDTH-1:0] reject_tot_ff;

   logic                   line_bad, line_reject;
   logic [BIN_WIDTH-1:0]   bin_sel;

   // the line register frees up as its word moves to the output register
   assign judge_fire     = evt_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall      = evt_valid_ff && !judge_fire;
   assign req_accept     = req_valid && !req_stall;
   assign newline_accept = req_accept && (req_data_byte == CHAR_NEWLINE);

   idgrh_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_accept),
      .data_byte   (req_data_byte),
      .line_snap   (cur_snap)
   );

   always_comb begin
      min_id_in = min_id_ff;
      max_id_in = max_id_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_ID: min_id_in = csr_wdata;
            CSR_MAX_ID: max_id_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      line_bad    = sticky_ff || (min_id_ff > max_id_ff) || evt_snap_ff.too_long
                    || (evt_snap_ff.verdict == VERDICT_BAD);
      line_reject = (evt_snap_ff.verdict == VERDICT_REJECT)
                    || (evt_snap_ff.id < {1'b0, min_id_ff})
                    || (evt_snap_ff.id > {1'b0, max_id_ff})
                    || (evt_snap_ff.grade > GRADE_FULL);
      bin_sel     = bin_of(evt_snap_ff.grade);
      bin_new     = (bins_ff[bin_sel] == COUNT_MAX) ? COUNT_MAX : bins_ff[bin_sel] + 1'b1;

      evt_valid_in  = newline_accept ? 1'b1 : (judge_fire ? 1'b0 : evt_valid_ff);
      sticky_in     = sticky_ff;
      line_cnt_in   = line_cnt_ff;
      reject_cnt_in = reject_cnt_ff;
      status_in     = STATUS_ACCEPTED;
      bin_idx_in    = '0;
      bin_cnt_in    = '0;
      if (judge_fire) begin
         line_cnt_in = (line_cnt_ff == COUNT_MAX) ? COUNT_MAX : line_cnt_ff + 1'b1;
         if (line_bad) begin
            sticky_in = 1'b1;
            status_in = STATUS_MALFORMED;
         end else if (line_reject) begin
            status_in     = STATUS_REJECTED;
            reject_cnt_in = (reject_cnt_ff == COUNT_MAX) ? COUNT_MAX : reject_cnt_ff + 1'b1;
         end else begin
            status_in  = STATUS_ACCEPTED;
            bin_idx_in = bin_sel;
            bin_cnt_in = bin_new;
         end
      end
      rsp_valid_in = judge_fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_id_ff     <= ID_WIDTH'(22200000);
         max_id_ff     <= ID_WIDTH'(22299999);
         evt_valid_ff  <= 1'b0;
         sticky_ff     <= 1'b0;
         line_cnt_ff   <= '0;
         reject_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_BINS; i++) begin
            bins_ff[i] <= '0;
         end
      end else begin
         min_id_ff     <= min_id_in;
         max_id_ff     <= max_id_in;
         evt_valid_ff  <= evt_valid_in;
         sticky_ff     <= sticky_in;
         line_cnt_ff   <= line_cnt_in;
         reject_cnt_ff <= reject_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (judge_fire && !line_bad && !line_reject) begin
            bins_ff[bin_sel] <= bin_new;
         end
      end
   end

   // payload registers: hold the line snapshot and the result word
   always_ff @(posedge clock) begin
      if (newline_accept) begin
         evt_snap_ff <= cur_snap;
      end
      if (judge_fire) begin
         status_ff     <= status_in;
         line_num_ff   <= line_cnt_in;
         bin_idx_ff    <= bin_idx_in;
         bin_cnt_ff    <= bin_cnt_in;
         reject_tot_ff <= reject_cnt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_status  = status_ff;
   assign rsp_line_number  = line_num_ff;
   assign rsp_bin_index    = bin_idx_ff;
   assign rsp_bin_count    = bin_cnt_ff;
   assign rsp_reject_total = reject_tot_ff;

   `IDGRH_ASSERT_RST(a_sticky_holds, clock, reset, sticky_ff |=> sticky_ff, "sticky error dropped without reset")
   `IDGRH_ASSERT_RST(a_bad_sets_sticky, clock, reset, (judge_fire && line_bad) |=> (sticky_ff && rsp_valid_ff && (status_ff == STATUS_MALFORMED)), "malformed line did not set sticky error")
   `IDGRH_ASSERT_RST(a_no_bin_unless_accepted, clock, reset, (rsp_valid_ff && (status_ff != STATUS_ACCEPTED)) |-> ((bin_idx_ff == '0) && (bin_cnt_ff == '0)), "bin fields set on a line that was not accepted")
   `IDGRH_ASSERT_ALWAYS(a_stall_only_when_full, clock, req_stall |-> (evt_valid_ff && rsp_valid_ff), "input stalled with room in the pipeline")

endmodule

// File: tb/sv/id_grade_record_histogram_unit_tb.sv
// Self-checking testbench for the grade-record histogram unit.
`timescale 1ns / 1ps
module id_grade_record_histogram_unit_tb;
   import idgrh_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 6;
   localparam int DRAIN_LIMIT   = 4000;

   typedef enum logic [2:0] {
      PS_START, PS_LEAD, PS_ID, PS_ID_GAP, PS_COMMA, PS_GRADE_GAP, PS_GRADE, PS_TAIL
   } parse_state_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [COUNT_WIDTH-1:0] line_no;
      logic [BIN_WIDTH-1:0]   bin;
      logic [COUNT_WIDTH-1:0] count;
      logic [COUNT_WIDTH-1:0] rejects;
   } line_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_line_status;
   logic [23:0]            rsp_line_number;
   logic [3:0]             rsp_bin_index;
   logic [23:0]            rsp_bin_count;
   logic [23:0]            rsp_reject_total;
   logic                   csr_wr_en = 1'b0;
   logic                   csr_index = CSR_MIN_ID;
   logic [30:0]            csr_wdata = '0;

   // line predictor state
   logic [ID_WIDTH-1:0]    lo_id;
   logic [ID_WIDTH-1:0]    hi_id;
   parse_state_type        scan_state;
   logic [ACC_WIDTH-1:0]   id_acc;
   logic [GRADE_WIDTH-1:0] grade_acc;
   logic [1:0]             line_verdict;
   logic [LEN_WIDTH-1:0]   line_len;
   logic [COUNT_WIDTH-1:0] line_tally;
   logic [COUNT_WIDTH-1:0] reject_tally;
   logic                   sticky_bad;
   logic [COUNT_WIDTH-1:0] bin_tally [NUM_BINS];

   line_result_type        pending_lines[$];
   logic [7:0]             line_buf[$];
   logic                   idling_on = 1'b1;
   int                     error_count = 0;
   int                     bytes_sent = 0;
   int                     lines_checked = 0;
   int                     status_seen [3] = '{0, 0, 0};
   int                     cycle_count = 0;

   id_grade_record_histogram_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_status  (rsp_line_status),
      .rsp_line_number  (rsp_line_number),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_reject_total (rsp_reject_total),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("id_grade_record_histogram_unit_tb: errors");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic void clear_histogram();
      scan_state   = PS_START;
      id_acc       = '0;
      grade_acc    = '0;
      line_verdict = VERDICT_PARSING;
      line_len     = '0;
      line_tally   = '0;
      reject_tally = '0;
      sticky_bad   = 1'b0;
      lo_id        = 31'd22200000;
      hi_id        = 31'd22299999;
      for (int k = 0; k < NUM_BINS; k++) bin_tally[k] = '0;
   endfunction

   function automatic void scan_char(input logic [7:0] c);
      logic       is_digit;
      logic       is_blank;
      logic [3:0] d;
      logic [35:0] id_wide;
      logic [13:0] grade_wide;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
      d = c[3:0];
      id_wide = {4'b0, id_acc} * 36'd10 + 36'(d);
      grade_wide = {4'b0, grade_acc} * 14'd10 + 14'(d);
      if (c == CHAR_NUL) begin
         line_verdict = VERDICT_STOPPED;
         return;
      end
      case (scan_state)
         PS_START, PS_LEAD: begin
            if (is_blank) scan_state = PS_LEAD;
            else if (is_digit) begin
               id_acc = 32'(d);
               scan_state = PS_ID;
            end else line_verdict = VERDICT_BAD;
         end
         PS_ID: begin
            if (is_digit) id_acc = (id_wide > 36'hFFFF_FFFF) ? '1 : id_wide[31:0];
            else if (is_blank) scan_state = PS_ID_GAP;
            else if (c == CHAR_COMMA) scan_state = PS_COMMA;
            else line_verdict = VERDICT_BAD;
         end
         PS_ID_GAP: begin
            if (is_blank) scan_state = PS_ID_GAP;
            else if (c == CHAR_COMMA) scan_state = PS_COMMA;
            else line_verdict = VERDICT_BAD;
         end
         PS_COMMA, PS_GRADE_GAP: begin
            if (is_digit) begin
               grade_acc = 10'(d);
               scan_state = PS_GRADE;
            end else if (is_blank) scan_state = PS_GRADE_GAP;
            else if (c == CHAR_MINUS) line_verdict = VERDICT_REJECT;
            else line_verdict = VERDICT_BAD;
         end
         PS_GRADE: begin
            if (is_digit) grade_acc = (grade_wide > 14'd1023) ? 10'd1023 : grade_wide[9:0];
            else if (is_blank) scan_state = PS_TAIL;
            else if (c == CHAR_MINUS) line_verdict = VERDICT_REJECT;
            else line_verdict = VERDICT_BAD;
         end
         default: begin
            if (!is_blank) line_verdict = VERDICT_BAD;
         end
      endcase
   endfunction

   function automatic void take_byte(input logic [7:0] c);
      line_result_type r;
      if (c != CHAR_NEWLINE) begin
         if (line_len != 7'd127) line_len = line_len + 1'b1;
         if (line_verdict == VERDICT_PARSING) scan_char(c);
         return;
      end
      r = '0;
      line_tally = bump(line_tally);
      if (sticky_bad || lo_id > hi_id || line_len > MAX_LINE_LEN ||
          line_verdict == VERDICT_BAD) begin
         sticky_bad = 1'b1;
         r.status = STATUS_MALFORMED;
      end else if (line_verdict == VERDICT_REJECT || id_acc < {1'b0, lo_id} ||
                   id_acc > {1'b0, hi_id} || grade_acc > GRADE_FULL) begin
         r.status = STATUS_REJECTED;
         reject_tally = bump(reject_tally);
      end else begin
         r.status = STATUS_ACCEPTED;
         r.bin = (grade_acc >= GRADE_FULL) ? 4'd9 : 4'(grade_acc / 10);
         bin_tally[r.bin] = bump(bin_tally[r.bin]);
         r.count = bin_tally[r.bin];
      end
      r.line_no = line_tally;
      r.rejects = reject_tally;
      pending_lines.push_back(r);
      scan_state   = PS_START;
      id_acc       = '0;
      grade_acc    = '0;
      line_verdict = VERDICT_PARSING;
      line_len     = '0;
   endfunction

   // ---------------- checking ----------------

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      line_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_lines.size() == 0) begin
               report_mismatch($sformatf("result word for line %0d with none expected",
                                         rsp_line_number));
            end else begin
               want = pending_lines.pop_front();
               lines_checked++;
               status_seen[want.status]++;
               if (rsp_line_status !== want.status)
                  report_mismatch($sformatf("line %0d status %0d, want %0d",
                                            want.line_no, rsp_line_status, want.status));
               if (rsp_line_number !== want.line_no)
                  report_mismatch($sformatf("line_number %0d, want %0d",
                                            rsp_line_number, want.line_no));
               if (rsp_bin_index !== want.bin)
                  report_mismatch($sformatf("line %0d bin_index %0d, want %0d",
                                            want.line_no, rsp_bin_index, want.bin));
               if (rsp_bin_count !== want.count)
                  report_mismatch($sformatf("line %0d bin_count %0d, want %0d",
                                            want.line_no, rsp_bin_count, want.count));
               if (rsp_reject_total !== want.rejects)
                  report_mismatch($sformatf("line %0d reject_total %0d, want %0d",
                                            want.line_no, rsp_reject_total, want.rejects));
            end
         end
         if (req_valid && !req_stall) take_byte(req_data_byte);
      end
   end

   // ---------------- result-side stall ----------------

   always begin : stall_gen
      int unsigned span;
      @(posedge clock);
      if (idling_on && $urandom_range(0, 2) == 0) begin
         span = $urandom_range(1, 13);
         rsp_stall <= 1'b1;
         repeat (span) @(posedge clock);
         rsp_stall <= 1'b0;
      end else begin
         span = $urandom_range(1, 30);
         rsp_stall <= 1'b0;
         repeat (span - 1) @(posedge clock);
      end
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_byte(input logic [7:0] b);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // drop valid and wait until every line result has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < DRAIN_LIMIT && pending_lines.size() != 0; k++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_id_range(input logic [30:0] lo, input logic [30:0] hi);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MIN_ID;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_MAX_ID;
      csr_wdata <= hi;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lo_id = lo;
      hi_id = hi;
   endtask

   function automatic void put_text(input string s);
      for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
   endfunction

   function automatic void put_blanks(input int most);
      int n;
      n = $urandom_range(0, most);
      repeat (n) line_buf.push_back($urandom_range(0, 1) ? CHAR_TAB : CHAR_SPACE);
   endfunction

   function automatic void put_junk(input int most);
      logic [7:0] b;
      repeat ($urandom_range(1, most)) begin
         b = 8'($urandom_range(1, 255));
         if (b == CHAR_NEWLINE) b = CHAR_MINUS;
         line_buf.push_back(b);
      end
   endfunction

   task automatic send_line();
      line_buf.push_back(CHAR_NEWLINE);
      foreach (line_buf[k]) send_byte(line_buf[k]);
      line_buf.delete();
   endtask

   task automatic send_text(input string s);
      line_buf.delete();
      put_text(s);
      send_line();
   endtask

   task automatic send_record(input longint unsigned id, input longint unsigned grade);
      line_buf.delete();
      put_blanks(2);
      put_text($sformatf("%0d", id));
      put_blanks(2);
      line_buf.push_back(CHAR_COMMA);
      put_blanks(2);
      put_text($sformatf("%0d", grade));
      put_blanks(2);
      send_line();
   endtask

   // well-formed record with random content; some carry a minus, a zero byte
   // or stop early, none of which makes the line malformed
   task automatic send_random_record();
      longint unsigned id;
      longint unsigned grade;
      int              pick;
      int              cut;
      pick = $urandom_range(0, 9);
      if (pick <= 5) id = lo_id + $urandom_range(0, hi_id - lo_id);
      else if (pick == 6) id = (lo_id != 0) ? lo_id - 1 : longint'(hi_id) + 1;
      else if (pick == 7) id = longint'(hi_id) + 1;
      else if (pick == 8) id = $urandom;
      else id = (longint'($urandom_range(0, 255)) << 32) | $urandom;
      pick = $urandom_range(0, 9);
      if (pick <= 7) grade = $urandom_range(0, 100);
      else if (pick == 8) grade = 100;
      else grade = $urandom_range(101, 99999);
      line_buf.delete();
      pick = $urandom_range(0, 19);
      put_blanks(3);
      if (pick == 4) put_text("00");
      put_text($sformatf("%0d", id));
      put_blanks(3);
      line_buf.push_back(CHAR_COMMA);
      put_blanks(3);
      if (pick == 0) begin
         line_buf.push_back(CHAR_MINUS);
         put_junk(6);
      end else begin
         if (pick == 4) put_text("0");
         put_text($sformatf("%0d", grade));
         if (pick == 1) begin
            line_buf.push_back(CHAR_MINUS);
            put_junk(6);
         end else begin
            put_blanks(3);
         end
      end
      if (pick == 2) begin
         cut = $urandom_range(0, line_buf.size());
         while (line_buf.size() > cut) void'(line_buf.pop_back());
      end else if (pick == 3) begin
         line_buf.push_back(CHAR_NUL);
         put_junk(8);
      end
      send_line();
   endtask

   // ---------------- tests ----------------

   task automatic test_basic_lines();
      send_text("22200000,0");
      send_text("22299999,100");
      send_text(" \t22250000 \t, \t9 \t");
      send_text("22250000,10");
      send_text("22250000,99");
      send_text("22250000,101");
      send_text("22199999,50");
      send_text("22300000,50");
      send_text("22250000,-5");
      send_text("22250000, 5-");
      send_text("0022250000,007");
      send_text("");
      send_text("22250000");
      send_text("22250000 ,");
      send_text("99999999999,50");
      send_text("22250000,99999");
      // zero byte freezes the line; the rest goes unparsed
      line_buf.delete();
      put_text("22250001,42");
      line_buf.push_back(CHAR_NUL);
      put_text("-,x");
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h80);
      send_line();
      line_buf.delete();
      line_buf.push_back(CHAR_NUL);
      put_text("22250002,3");
      send_line();
   endtask

   task automatic test_id_range_settings();
      logic [30:0] lo_set [5];
      logic [30:0] hi_set [5];
      lo_set[0] = '0;           hi_set[0] = '1;
      lo_set[1] = '1;           hi_set[1] = '1;
      lo_set[2] = '0;           hi_set[2] = '0;
      lo_set[3] = 31'($urandom_range(0, 32'h7FF0_0000));
      hi_set[3] = lo_set[3] + 31'($urandom_range(0, 500000));
      lo_set[4] = 31'($urandom_range(0, 32'h7FFF_FFFF));
      hi_set[4] = lo_set[4];
      for (int s = 0; s < 5; s++) begin
         settle();
         write_id_range(lo_set[s], hi_set[s]);
         send_record(lo_id, $urandom_range(0, 100));
         send_record(hi_id, $urandom_range(0, 100));
         if (lo_id != 0) send_record(lo_id - 1, $urandom_range(0, 100));
         send_record(longint'(hi_id) + 1, $urandom_range(0, 100));
         send_record(64'h7FFF_FFFF, 100);
         send_record(64'h8000_0000, 0);
         send_record(64'hFFFF_FFFF, 50);
         send_record(64'h1_0000_0000, 50);
      end
   endtask

   task automatic test_random_records();
      int stop_at;
      logic [30:0] lo;
      for (int s = 0; s < 2; s++) begin
         settle();
         lo = 31'($urandom_range(0, 32'h7000_0000));
         write_id_range(lo, lo + 31'($urandom_range(0, 32'h0FFF_FFFF)));
         stop_at = bytes_sent + 50;
         while (bytes_sent < stop_at) send_random_record();
      end
   endtask

   task automatic test_line_length();
      line_buf.delete();
      put_text($sformatf("%0d,55", lo_id));
      while (line_buf.size() < MAX_LINE_LEN) line_buf.push_back(CHAR_SPACE);
      send_line();
      // one byte over: malformed, and the error sticks from here on
      line_buf.delete();
      put_text($sformatf("%0d,55", lo_id));
      while (line_buf.size() < MAX_LINE_LEN + 1) line_buf.push_back(CHAR_SPACE);
      send_line();
   endtask

   task automatic test_sticky_error();
      logic [7:0] b;
      idling_on = 1'b0;
      send_record(lo_id, 20);
      send_text("ab,1");
      send_text("1-2,3");
      send_text(",5");
      settle();
      write_id_range('1, '0);
      send_record(5, 5);
      line_buf.delete();
      repeat (110) line_buf.push_back(8'h78);
      send_line();
      repeat (30) begin
         b = ($urandom_range(0, 7) == 0) ? CHAR_NEWLINE : 8'($urandom_range(0, 255));
         send_byte(b);
      end
      send_byte(CHAR_NEWLINE);
   endtask

   initial begin
      clear_histogram();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_basic_lines();
      test_id_range_settings();
      test_random_records();
      test_line_length();
      test_sticky_error();
      settle();
      if (pending_lines.size() != 0)
         report_mismatch($sformatf("%0d line results never arrived", pending_lines.size()));
      $display("sent %0d bytes over %0d checked lines", bytes_sent, lines_checked);
      $display("accepted %0d, rejected %0d, malformed %0d; %0d mismatches",
               status_seen[0], status_seen[1], status_seen[2], error_count);
      if (error_count == 0) begin
         $display("id_grade_record_histogram_unit_tb: clean");
      end else begin
         $display("id_grade_record_histogram_unit_tb: errors");
      end
      $finish;
   end

endmodule
